>>> hdl/lsasmw_pkg.sv
// Shared types and constants for the limb-serial add/sub/multiply-by-word block.
// No dependencies; every other file imports this package.
package lsasmw_pkg;

    typedef logic [63:0] t_limb;

    // Decimal limb radix 10^18; it fits in the low 60 bits.
    localparam t_limb DEC_BASE = 64'd1000000000000000000;
    // Reciprocal of the decimal radix, floor(2^123 / 10^18)
    localparam t_limb DEC_RECIP = 64'd10633823966279326983;

    // Configuration register indexes
    localparam logic [1:0] CFG_DECIMAL_RADIX = 2'd0;
    localparam logic [1:0] CFG_OPERATION     = 2'd1;
    localparam logic [1:0] CFG_MULTIPLIER    = 2'd2;
    localparam logic [1:0] CFG_INITIAL_CARRY = 2'd3;

    // Operation codes; the reserved code acts as add
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Request from the top-level sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic dec;
    } t_md_req;

endpackage

>>> hdl/lsasmw_in_if.sv
// Input limb channel: valid/ready handshake plus limb payload.
// Depends on lsasmw_pkg.
interface lsasmw_in_if import lsasmw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_limb a_limb;
    t_limb b_limb;
    logic  first;
    logic  last;

    modport source (output valid, a_limb, b_limb, first, last, input ready);
    modport sink   (input valid, a_limb, b_limb, first, last, output ready);
endinterface

>>> hdl/lsasmw_out_if.sv
// Result limb channel: valid/ready handshake plus result payload.
// Depends on lsasmw_pkg.
interface lsasmw_out_if import lsasmw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_limb result_limb;
    t_limb carry_out;
    logic  last_out;

    modport source (output valid, result_limb, carry_out, last_out, input ready);
    modport sink   (input valid, result_limb, carry_out, last_out, output ready);
endinterface

>>> hdl/limb_serial_add_sub_mul_word.sv
// Top level of the limb-serial add / subtract / multiply-by-word block.
// Depends on lsasmw_pkg, lsasmw_in_if, lsasmw_out_if and lsasmw_muldiv.
//
//   port    | dir | handshake      | payload
//   --------+-----+----------------+----------------------------------------
//   i_in    | in  | valid / ready  | a_limb, b_limb, first, last
//   o_out   | out | valid / ready  | result_limb, carry_out, last_out
//   i_cfg_* | in  | write enable   | register index (2 bits), data (64 bits)
//
// Add and subtract accept the limbs, then load the result. Binary multiply
// accepts, forms 4 partial products on the shared 32x32 multiplier, signals done
// and loads; decimal multiply reduces the product by 10^18 with a folded high
// word, a reciprocal estimate and its back-multiply (two more passes of 4 partial
// products) and up to three correction steps.
// The ready signal is high only while
// the sequencer is idle. A finished result sits in the output register while
// the next transaction is taken; the sequencer stalls only if it has a new
// result and that register is still full. Reset is synchronous, active low,
// and clears the sequencer, the running carry and all configuration registers.
module limb_serial_add_sub_mul_word import lsasmw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  t_limb         i_cfg_data,
    lsasmw_in_if.sink     i_in,
    lsasmw_out_if.source  o_out
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_MUL  = 3'b010,
        T_FIN  = 3'b100
    } t_state;

    // configuration
    logic       r_dec;
    logic [1:0] r_op;
    t_limb      r_mult;
    t_limb      r_init;

    // sequencer and operands
    t_state r_state;
    t_limb  r_run;
    t_limb  r_a;
    t_limb  r_b;
    t_limb  r_c;
    logic   r_last;

    // output register
    logic   r_out_valid;
    t_limb  r_res;
    t_limb  r_cout;
    logic   r_last_out;

    logic    accept;
    logic    out_free;
    t_limb   carry_in;
    t_md_req md_req;
    logic    md_done;
    t_limb   md_lo;
    t_limb   md_hi;

    logic [64:0] sum;
    logic [64:0] dif;
    logic        borrow;
    logic        over;
    t_limb       res;
    t_limb       nc;

    assign i_in.ready = (r_state == T_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    // first limb reloads the carry from the configured value
    assign carry_in   = i_in.first ? r_init : r_run;

    assign md_req.start = accept && (r_op == OP_MUL);
    assign md_req.dec   = r_dec;

    lsasmw_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (i_in.a_limb),
        .i_m     (r_mult),
        .i_c     (carry_in),
        .o_done  (md_done),
        .o_lo    (md_lo),
        .o_hi    (md_hi)
    );

    // Add and subtract work on bit 0 of the carry only. Decimal add takes
    // 10^18 off once when the unwrapped sum reaches it; decimal subtract adds
    // 10^18 back on a borrow. Results wrap modulo 2^64.
    always_comb begin
        sum    = {1'b0, r_a} + {1'b0, r_b} + {64'b0, r_c[0]};
        dif    = {1'b0, r_a} - {1'b0, r_b} - {64'b0, r_c[0]};
        borrow = dif[64];
        over   = r_dec && (sum >= {1'b0, DEC_BASE});
        case (r_op)
            OP_MUL: begin
                res = md_lo;
                nc  = md_hi;
            end
            OP_SUB: begin
                res = dif[63:0] + ((r_dec && borrow) ? DEC_BASE : 64'd0);
                nc  = {63'b0, borrow};
            end
            default: begin
                res = over ? (sum[63:0] - DEC_BASE) : sum[63:0];
                nc  = r_dec ? {63'b0, over} : {63'b0, sum[64]};
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec  <= 1'b0;
            r_op   <= OP_ADD;
            r_mult <= '0;
            r_init <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DECIMAL_RADIX: r_dec  <= i_cfg_data[0];
                CFG_OPERATION:     r_op   <= i_cfg_data[1:0];
                CFG_MULTIPLIER:    r_mult <= i_cfg_data;
                CFG_INITIAL_CARRY: r_init <= i_cfg_data;
                default:           r_dec  <= r_dec;
            endcase
        end
    end

    // sequencer, running carry and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output once the sink takes it, unless a new one loads
            if (r_out_valid && o_out.ready && (r_state != T_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_a     <= i_in.a_limb;
                        r_b     <= i_in.b_limb;
                        r_c     <= carry_in;
                        r_last  <= i_in.last;
                        r_state <= (r_op == OP_MUL) ? T_MUL : T_FIN;
                    end
                end
                T_MUL: begin
                    if (md_done) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    // hold here until the output register has room
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_res       <= res;
                        r_cout      <= nc;
                        r_last_out  <= r_last;
                        r_run       <= nc;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_limb = r_res;
    assign o_out.carry_out   = r_cout;
    assign o_out.last_out    = r_last_out;

endmodule

>>> hdl/lsasmw_muldiv.sv
// Shared multiply/divide unit: a*m + c on one 32x32 multiplier,
// then optional reduction by 10^18 through a reciprocal estimate and corrections.
// Depends on lsasmw_pkg.
module lsasmw_muldiv import lsasmw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    input  t_limb   i_a,
    input  t_limb   i_m,
    input  t_limb   i_c,
    output logic    o_done,
    output t_limb   o_lo,
    output t_limb   o_hi
);

    typedef enum logic [7:0] {
        U_IDLE = 8'b0000_0001,
        U_MUL  = 8'b0000_0010,
        U_RED  = 8'b0000_0100,
        U_FOLD = 8'b0000_1000,
        U_QSET = 8'b0001_0000,
        U_REM  = 8'b0010_0000,
        U_FIX  = 8'b0100_0000,
        U_DONE = 8'b1000_0000
    } t_ustate;

    // which product the shared multiplier is forming
    typedef enum logic [2:0] {
        P_PROD = 3'b001,
        P_QEST = 3'b010,
        P_QD   = 3'b100
    } t_pass;

    t_ustate       r_state;
    t_pass         r_pass;
    logic [1:0]    r_cnt;
    logic          r_dec;
    t_limb         r_x;
    t_limb         r_y;
    logic [127:0]  r_acc;
    t_limb         r_lo;
    t_limb         r_q;
    t_limb         r_rem;

    logic [31:0]   half_a;
    logic [31:0]   half_m;
    logic [63:0]   pp;
    logic [127:0]  addend;
    logic [68:0]   hi18;
    t_limb         red_est;
    logic [59:0]   fold_r1;

    always_comb begin
        half_a = r_cnt[0] ? r_x[63:32] : r_x[31:0];
        half_m = r_cnt[1] ? r_y[63:32] : r_y[31:0];
        pp     = half_a * half_m;
        case (r_cnt[1:0])
            2'b00:        addend = {64'b0, pp};
            2'b01, 2'b10: addend = {32'b0, pp, 32'b0};
            default:      addend = {pp, 64'b0};
        endcase
        // hi div 10^18 estimated as floor(18*hi / 2^64), low by at most one
        hi18    = {1'b0, r_acc[127:64], 4'b0} + {4'b0, r_acc[127:64], 1'b0};
        red_est = r_acc[127:64] - 64'(hi18[68:64]) * DEC_BASE;
        fold_r1 = (r_rem >= DEC_BASE) ? 60'(r_rem - DEC_BASE) : r_rem[59:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_a;
                        r_y     <= i_m;
                        r_acc   <= {64'b0, i_c};
                        r_dec   <= i_req.dec;
                        r_pass  <= P_PROD;
                        r_cnt   <= '0;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_acc <= r_acc + addend;
                    r_cnt <= r_cnt + 2'd1;
                    if (&r_cnt) begin
                        unique case (r_pass)
                            P_PROD:  r_state <= r_dec ? U_RED : U_DONE;
                            P_QEST:  r_state <= U_QSET;
                            P_QD:    r_state <= U_REM;
                            default: r_state <= U_DONE;
                        endcase
                    end
                end
                U_RED: begin
                    r_lo    <= r_acc[63:0];
                    r_rem   <= red_est;
                    r_state <= U_FOLD;
                end
                U_FOLD: begin
                    // quotient estimate from the top 64 bits of (hi mod 10^18):lo
                    r_x     <= {fold_r1, r_lo[63:60]};
                    r_y     <= DEC_RECIP;
                    r_acc   <= '0;
                    r_pass  <= P_QEST;
                    r_state <= U_MUL;
                end
                U_QSET: begin
                    r_q     <= r_acc[126:63];
                    r_x     <= r_acc[126:63];
                    r_y     <= DEC_BASE;
                    r_acc   <= '0;
                    r_pass  <= P_QD;
                    r_state <= U_MUL;
                end
                U_REM: begin
                    // the estimate is at most three low, so this fits 64 bits
                    r_rem   <= r_lo - r_acc[63:0];
                    r_state <= U_FIX;
                end
                U_FIX: begin
                    if (r_rem >= DEC_BASE) begin
                        r_rem <= r_rem - DEC_BASE;
                        r_q   <= r_q + 64'd1;
                    end else begin
                        r_state <= U_DONE;
                    end
                end
                U_DONE: begin
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == U_DONE);
    assign o_lo   = r_dec ? r_rem : r_acc[63:0];
    assign o_hi   = r_dec ? r_q : r_acc[127:64];

endmodule

>>> verif/lsasmw_checker.sv
// Scoreboard for the limb-serial add/subtract/multiply-by-word block.
// Watches the config port and both channels, predicts each result limb.
// Depends on lsasmw_pkg, lsasmw_in_if and lsasmw_out_if.
module lsasmw_checker import lsasmw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  t_limb      i_cfg_data,
    lsasmw_in_if       i_in_mon,
    lsasmw_out_if      i_out_mon,
    output int         o_errors,
    output int         o_results,
    output int         o_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_limb result_limb;
        t_limb carry_out;
        logic  last_out;
    } t_limb_result;

    // Shadow copies of the configuration and the carry chain
    logic       dec_mode;
    logic [1:0] op_mode;
    t_limb      mult_word;
    t_limb      init_carry;
    t_limb      carry_q;

    t_limb_result limb_results_q[$];
    int err_cnt;
    int seen_cnt;

    function automatic t_limb_result predict_limb(t_limb a, t_limb b, logic first,
                                                  logic last);
        t_limb        c;
        logic         bit0;
        logic [127:0] wide;
        logic [127:0] quo;
        logic [64:0]  sum;
        logic         over;
        logic         borrow;
        t_limb_result res;
        c            = first ? init_carry : carry_q;
        bit0         = c[0];
        res.last_out = last;
        case (op_mode)
            OP_MUL: begin
                wide = {64'd0, a} * {64'd0, mult_word} + {64'd0, c};
                if (dec_mode) begin
                    quo             = wide / {64'd0, DEC_BASE};
                    res.result_limb = t_limb'(wide - quo * {64'd0, DEC_BASE});
                    res.carry_out   = quo[63:0];
                end else begin
                    res.result_limb = wide[63:0];
                    res.carry_out   = wide[127:64];
                end
            end
            OP_SUB: begin
                // borrow compares without wrap
                borrow          = {1'b0, a} < ({1'b0, b} + 65'(bit0));
                res.result_limb = a - b - 64'(bit0);
                if (dec_mode && borrow)
                    res.result_limb = res.result_limb + DEC_BASE;
                res.carry_out   = 64'(borrow);
            end
            default: begin
                // add, and the reserved code behaves the same
                sum             = {1'b0, a} + {1'b0, b} + 65'(bit0);
                over            = dec_mode ? (sum >= {1'b0, DEC_BASE}) : sum[64];
                res.result_limb = (dec_mode && over) ? sum[63:0] - DEC_BASE : sum[63:0];
                res.carry_out   = 64'(over);
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_limb_result want;
        t_limb_result got;
        if (!i_rst_n) begin
            dec_mode   = 1'b0;
            op_mode    = OP_ADD;
            mult_word  = '0;
            init_carry = '0;
            carry_q    = '0;
            limb_results_q.delete();
        end else begin
            // retire the oldest expectation first
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.result_limb, i_out_mon.carry_out, i_out_mon.last_out};
                seen_cnt++;
                if (limb_results_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("ERROR %0t: unexpected result limb %h carry %h last %b",
                                 $time, got.result_limb, got.carry_out, got.last_out);
                end else begin
                    want = limb_results_q.pop_front();
                    if (got.result_limb !== want.result_limb ||
                        got.carry_out !== want.carry_out ||
                        got.last_out !== want.last_out) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                            $display({"ERROR %0t: expected limb %h carry %h last %b,",
                                      " got limb %h carry %h last %b"}, $time,
                                     want.result_limb, want.carry_out, want.last_out,
                                     got.result_limb, got.carry_out, got.last_out);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECIMAL_RADIX: dec_mode   = i_cfg_data[0];
                    CFG_OPERATION:     op_mode    = i_cfg_data[1:0];
                    CFG_MULTIPLIER:    mult_word  = i_cfg_data;
                    CFG_INITIAL_CARRY: init_carry = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                want = predict_limb(i_in_mon.a_limb, i_in_mon.b_limb, i_in_mon.first,
                                    i_in_mon.last);
                limb_results_q.push_back(want);
                carry_q = want.carry_out;
            end
        end
        o_errors  <= err_cnt;
        o_results <= seen_cnt;
        o_left    <= limb_results_q.size();
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for limb_serial_add_sub_mul_word: clock, reset, stimulus, verdict.
// Depends on lsasmw_pkg, both channel interfaces, the block and lsasmw_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsasmw_pkg::*;

    // Reserved operation code; the block treats it as add
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int ITEM_TARGET  = 1050;
    localparam int DRAIN_CYCLES = 150;      // longer than a decimal multiply
    localparam int CYCLE_LIMIT  = 1000000;  // several times the slowest legal run
    localparam t_limb ALL_ONES  = '1;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_DECIMAL_RADIX;
    t_limb      i_cfg_data = '0;

    lsasmw_in_if  in_ch ();
    lsasmw_out_if out_ch ();

    int chk_errors;
    int chk_results;
    int chk_left;

    int sent        = 0;
    int nsettings   = 0;
    int burst_left  = 0;
    int cycle_cnt   = 0;
    int stall_left  = 0;
    int rx_mode     = 0;
    int rx_mode_left = 0;

    limb_serial_add_sub_mul_word uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lsasmw_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_errors   (chk_errors),
        .o_results  (chk_results),
        .o_left     (chk_left)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
                     sent - chk_results);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: switch between no stalls, scattered stalls and long
    // stall stretches so back-pressure lands on every phase of the sequencer.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 300);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
        endcase
    end

    // Limb value biased toward the edges; in decimal radix mostly in range,
    // with an occasional out-of-range word
    function automatic t_limb rand_limb(logic dec);
        t_limb v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return dec ? DEC_BASE - 64'd1 : ALL_ONES - 64'd1;
            3:       return 64'($urandom_range(0, 15));
            4:       return dec ? DEC_BASE + 64'($urandom_range(0, 3)) : v;
            5:       return v;
            default: return dec ? v % DEC_BASE : v;
        endcase
    endfunction

    // Present one limb transaction and hold it until the block takes it.
    // Between bursts, drop valid for a random gap.
    task automatic send_limb(input t_limb a, input t_limb b, input logic first,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.a_limb <= a;
        in_ch.b_limb <= b;
        in_ch.first  <= first;
        in_ch.last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    // Hold off until every sent limb has come back; the block is idle then
    task automatic wait_drained;
        in_ch.valid <= 1'b0;
        while (chk_results < sent) @(posedge i_clk);
    endtask

    // Write all four registers back to back, once the block is idle
    task automatic load_settings(input logic dec, input logic [1:0] op, input t_limb mult,
                                 input t_limb carry0);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DECIMAL_RADIX;
        i_cfg_data <= 64'(dec);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OPERATION;
        i_cfg_data <= 64'(op);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MULTIPLIER;
        i_cfg_data <= mult;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INITIAL_CARRY;
        i_cfg_data <= carry0;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        nsettings++;
    endtask

    initial begin
        logic       dec;
        logic [1:0] op;
        logic       noisy;
        logic       f;
        logic       l;
        int         quota;
        int         len;
        int         blen;
        in_ch.valid  = 1'b0;
        in_ch.a_limb = '0;
        in_ch.b_limb = '0;
        in_ch.first  = 1'b0;
        in_ch.last   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: binary add, carry chain starts from zero
        send_limb(ALL_ONES, 64'd1, 1'b0, 1'b0);
        send_limb(64'd5, 64'd5, 1'b1, 1'b1);

        // Binary add: carry ripples through all-ones limbs
        load_settings(1'b0, OP_ADD, '0, 64'd1);
        send_limb(ALL_ONES, ALL_ONES, 1'b1, 1'b0);
        send_limb(ALL_ONES, '0, 1'b0, 1'b0);
        send_limb('0, '0, 1'b0, 1'b1);

        // Binary subtract: borrow in and out
        load_settings(1'b0, OP_SUB, '0, 64'd1);
        send_limb('0, ALL_ONES, 1'b1, 1'b0);
        send_limb('0, '0, 1'b0, 1'b1);

        // Binary multiply: largest product plus largest addend
        load_settings(1'b0, OP_MUL, ALL_ONES, ALL_ONES);
        send_limb(ALL_ONES, 64'h1234, 1'b1, 1'b0);
        send_limb(ALL_ONES, '0, 1'b0, 1'b1);

        // Decimal add: in range, then limbs past 10^18
        load_settings(1'b1, OP_ADD, '0, 64'd1);
        send_limb(DEC_BASE - 64'd1, DEC_BASE - 64'd1, 1'b1, 1'b0);
        send_limb(ALL_ONES, ALL_ONES, 1'b0, 1'b1);

        // Decimal subtract: borrow, then a b limb out of range
        load_settings(1'b1, OP_SUB, '0, 64'd1);
        send_limb('0, DEC_BASE - 64'd1, 1'b1, 1'b0);
        send_limb(64'd5, ALL_ONES, 1'b0, 1'b1);

        // Decimal multiply: largest in range, then an a limb out of range;
        // the carry continues past last with no new first
        load_settings(1'b1, OP_MUL, DEC_BASE - 64'd1, DEC_BASE - 64'd1);
        send_limb(DEC_BASE - 64'd1, '0, 1'b1, 1'b0);
        send_limb(ALL_ONES, '0, 1'b0, 1'b1);
        send_limb('0, '0, 1'b0, 1'b1);

        // Decimal multiply with a quotient that wraps modulo 2^64
        load_settings(1'b1, OP_MUL, ALL_ONES, ALL_ONES);
        send_limb(ALL_ONES, '0, 1'b1, 1'b1);

        // Reserved code acts as add; only bit 0 of the initial carry counts
        load_settings(1'b0, OP_RESERVED, '0, 64'd2);
        send_limb(64'd1, 64'd2, 1'b1, 1'b1);
        send_limb(ALL_ONES, 64'd1, 1'b0, 1'b1);

        // Random phases: new settings, then mostly well-formed operands of
        // random length; now and then scramble the first/last flags
        while (sent < ITEM_TARGET) begin
            dec = 1'($urandom_range(0, 1));
            op  = ($urandom_range(0, 9) == 0) ? OP_RESERVED : 2'($urandom_range(0, 2));
            load_settings(dec, op, rand_limb(dec), rand_limb(dec));
            quota = sent + $urandom_range(20, 60);
            while (sent < quota) begin
                noisy = ($urandom_range(0, 9) == 0);
                len   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(1, 6);
                blen  = $urandom_range(0, len);
                for (int k = 0; k < len; k++) begin
                    f = (k == 0);
                    l = (k == len - 1);
                    if (noisy) begin
                        f = 1'($urandom_range(0, 1));
                        l = 1'($urandom_range(0, 1));
                    end
                    send_limb(rand_limb(dec), (k < blen) ? rand_limb(dec) : '0, f, l);
                end
            end
        end

        // Drain, then give the block time to show any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d limb transactions over %0d register settings, both radixes,",
                 sent, nsettings);
        $display("add/sub/multiply/reserved; %0d results checked, %0d mismatches.",
                 chk_results, chk_errors);
        if (chk_errors == 0 && chk_left == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lsasmw_pkg.sv
hdl/lsasmw_in_if.sv
hdl/lsasmw_out_if.sv
hdl/lsasmw_muldiv.sv
hdl/limb_serial_add_sub_mul_word.sv
verif/lsasmw_checker.sv
verif/tb_top.sv
